[rtl/mfrd_pkg.sv]
// Shared types for the monochrome page frame buffer: request codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package mfrd_pkg;

  // Request codes carried on tuser. Code 3 is unused; it leaves the store alone but still returns a zero result.
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_RECT  = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  // Fixed geometry of the coordinate fields
  localparam int unsigned CoordW = 8;
  localparam int unsigned PageW  = CoordW - 3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RECT,
    ST_RD,
    ST_WR,
    ST_RDB,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch request fields, restart sub-rectangle index
    logic clr_step;   // write zero at sweep pointer, advance it
    logic rect_load;  // load bounds of the current sub-rectangle
    logic rect_next;  // move to the next sub-rectangle
    logic rd_draw;    // read store byte at walk address
    logic wr_draw;    // write modified byte, advance walk
    logic rd_byte;    // read store byte for a read request
    logic out_load;   // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       rect_empty;
    logic       sub_last;
    logic       walk_last;
    logic       out_busy;
  } sts_t;

endpackage

[rtl/mfrd_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module mfrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/mfrd_dp.sv]
// Datapath of the frame buffer: request registers, sub-rectangle bounds,
// byte walk counters, clear sweep, frame store RAM and result register.
// Depends on mfrd_pkg and mfrd_ram.
module mfrd_dp #(
  parameter int unsigned DISP_WIDTH  = 128,
  parameter int unsigned DISP_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfrd_pkg::cmd_t                cmd_i,
  output mfrd_pkg::sts_t                sts_o,
  input  logic [1:0]                    req_type_i,
  input  logic [mfrd_pkg::CoordW-1:0]   pos_x_i,
  input  logic [mfrd_pkg::CoordW-1:0]   pos_y_i,
  input  logic [mfrd_pkg::CoordW-1:0]   rect_width_i,
  input  logic [mfrd_pkg::CoordW-1:0]   rect_height_i,
  input  logic                          fill_mode_i,
  input  logic                          pixel_value_i,
  input  logic [9:0]                    byte_addr_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [7:0]                    out_data_o
);

  localparam int unsigned CW         = mfrd_pkg::CoordW;
  localparam int unsigned PW         = mfrd_pkg::PageW;
  localparam int unsigned Pages      = (DISP_HEIGHT + 7) / 8;
  localparam int unsigned StoreBytes = DISP_WIDTH * Pages;
  localparam int unsigned AW         = $clog2(StoreBytes);
  localparam int unsigned RW         = ((AW > 10) ? AW : 10) + 1;

  localparam logic [CW:0]   DispW  = (CW + 1)'(DISP_WIDTH);
  localparam logic [CW:0]   DispH  = (CW + 1)'(DISP_HEIGHT);
  localparam logic [AW-1:0] WidthA = AW'(DISP_WIDTH);

  // Request registers
  logic [1:0]    req_q;
  logic [CW-1:0] x_q, y_q, w_q, h_q;
  logic          fill_q, val_q;
  logic [9:0]    baddr_q;

  // Sub-rectangle index and walk state
  logic [1:0]    sub_q;
  logic [CW-1:0] xa_q, col_q, ya_q;
  logic [CW:0]   xe_q, ye_q;
  logic [PW-1:0] page_q, pe_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] clr_q;

  logic          out_valid_q;
  logic [7:0]    out_data_q;

  // Current sub-rectangle: origin and extent, before clipping
  logic [CW-1:0] x0, xl, y0, yl, yb, xr;
  logic [CW:0]   xsum, ysum, xend, yend, yend_m1;
  logic          empty, sub_last;

  assign yb = y_q + h_q - CW'(1);
  assign xr = x_q + w_q - CW'(1);

  always_comb begin
    x0 = x_q;
    xl = w_q;
    y0 = y_q;
    yl = h_q;
    if (!fill_q) begin
      case (sub_q)
        2'd0: begin
          yl = CW'(1);
        end
        2'd1: begin
          y0 = yb;
          yl = CW'(1);
        end
        2'd2: begin
          xl = CW'(1);
        end
        default: begin
          x0 = xr;
          xl = CW'(1);
        end
      endcase
    end
  end

  assign xsum     = {1'b0, x0} + {1'b0, xl};
  assign ysum     = {1'b0, y0} + {1'b0, yl};
  assign xend     = (xsum > DispW) ? DispW : xsum;
  assign yend     = (ysum > DispH) ? DispH : ysum;
  assign yend_m1  = yend - (CW + 1)'(1);
  assign empty    = ({1'b0, x0} >= xend) || ({1'b0, y0} >= yend);
  assign sub_last = fill_q || (sub_q == 2'd3);

  // Byte walk: address, row mask, modified byte
  logic [AW-1:0] walk_addr;
  logic [7:0]    mask, rdata, wbyte;
  logic          col_last, walk_last;

  assign walk_addr = base_q + AW'(col_q);
  assign col_last  = ({1'b0, col_q} == (xe_q - (CW + 1)'(1)));
  assign walk_last = col_last && (page_q == pe_q);

  always_comb begin
    logic [CW-1:0] yrow;
    for (int b = 0; b < 8; b++) begin
      yrow    = {page_q, 3'(b)};
      mask[b] = (yrow >= ya_q) && ({1'b0, yrow} < ye_q);
    end
  end

  assign wbyte = val_q ? (rdata | mask) : (rdata & ~mask);

  // Frame store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata;
  logic          in_range;

  assign ram_we    = cmd_i.clr_step || cmd_i.wr_draw;
  assign ram_waddr = cmd_i.clr_step ? clr_q : walk_addr;
  assign ram_wdata = cmd_i.clr_step ? 8'h00 : wbyte;
  assign ram_re    = cmd_i.rd_draw || cmd_i.rd_byte;
  assign ram_raddr = cmd_i.rd_byte ? AW'(baddr_q) : walk_addr;
  assign in_range  = (RW'(baddr_q) < RW'(StoreBytes));

  mfrd_ram #(
    .WIDTH (8),
    .DEPTH (StoreBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_type_i;
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      w_q     <= rect_width_i;
      h_q     <= rect_height_i;
      fill_q  <= fill_mode_i;
      val_q   <= pixel_value_i;
      baddr_q <= byte_addr_i;
    end
  end

  // Sub-rectangle index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else if (cmd_i.accept) begin
      sub_q <= '0;
    end else if (cmd_i.rect_next) begin
      sub_q <= sub_q + 2'd1;
    end
  end

  // Walk bounds and counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.rect_load) begin
      xa_q   <= x0;
      xe_q   <= xend;
      ya_q   <= y0;
      ye_q   <= yend;
      col_q  <= x0;
      page_q <= y0[CW-1:3];
      pe_q   <= yend_m1[CW-1:3];
      base_q <= AW'(y0[CW-1:3]) * WidthA;
    end else if (cmd_i.wr_draw) begin
      if (col_last) begin
        col_q  <= xa_q;
        page_q <= page_q + PW'(1);
        base_q <= base_q + WidthA;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Clear sweep pointer, wraps back to zero after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= sts_o.clr_last ? '0 : clr_q + AW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= ((req_q == mfrd_pkg::REQ_READ) && in_range) ? rdata : 8'h00;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.clr_last   = (clr_q == AW'(StoreBytes - 1));
  assign sts_o.rect_empty = empty;
  assign sts_o.sub_last   = sub_last;
  assign sts_o.walk_last  = walk_last;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

[rtl/mfrd_ctrl.sv]
// Controller of the frame buffer: sequences clear sweeps, rectangle byte walks
// and byte reads over the datapath. Depends on mfrd_pkg.
module mfrd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_req_i,
  output logic           in_ready_o,
  output mfrd_pkg::cmd_t cmd_o,
  input  mfrd_pkg::sts_t sts_i
);

  mfrd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfrd_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfrd_pkg::ST_INIT: begin
        if (sts_i.clr_last) state_d = mfrd_pkg::ST_IDLE;
      end
      mfrd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i)
            mfrd_pkg::REQ_CLEAR: state_d = mfrd_pkg::ST_CLEAR;
            mfrd_pkg::REQ_RECT:  state_d = mfrd_pkg::ST_RECT;
            mfrd_pkg::REQ_READ:  state_d = mfrd_pkg::ST_RDB;
            default:             state_d = mfrd_pkg::ST_DONE;
          endcase
        end
      end
      mfrd_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = mfrd_pkg::ST_DONE;
      end
      mfrd_pkg::ST_RECT: begin
        if (!sts_i.rect_empty) begin
          state_d = mfrd_pkg::ST_RD;
        end else if (sts_i.sub_last) begin
          state_d = mfrd_pkg::ST_DONE;
        end
      end
      mfrd_pkg::ST_RD: begin
        state_d = mfrd_pkg::ST_WR;
      end
      mfrd_pkg::ST_WR: begin
        if (!sts_i.walk_last) begin
          state_d = mfrd_pkg::ST_RD;
        end else if (sts_i.sub_last) begin
          state_d = mfrd_pkg::ST_DONE;
        end else begin
          state_d = mfrd_pkg::ST_RECT;
        end
      end
      mfrd_pkg::ST_RDB: begin
        state_d = mfrd_pkg::ST_DONE;
      end
      mfrd_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = mfrd_pkg::ST_IDLE;
      end
      default: begin
        state_d = mfrd_pkg::ST_INIT;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mfrd_pkg::ST_INIT, mfrd_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      mfrd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      mfrd_pkg::ST_RECT: begin
        cmd_o.rect_load = 1'b1;
        cmd_o.rect_next = sts_i.rect_empty && !sts_i.sub_last;
      end
      mfrd_pkg::ST_RD: begin
        cmd_o.rd_draw = 1'b1;
      end
      mfrd_pkg::ST_WR: begin
        cmd_o.wr_draw   = 1'b1;
        cmd_o.rect_next = sts_i.walk_last && !sts_i.sub_last;
      end
      mfrd_pkg::ST_RDB: begin
        cmd_o.rd_byte = 1'b1;
      end
      mfrd_pkg::ST_DONE: begin
        cmd_o.out_load = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/mono_framebuffer_rect_draw.sv]
// Sequence: a clear sweeps the whole store; a read fetches the addressed byte;
//   a rectangle loads each sub-rectangle (one when filled, four for an outline)
//   and reads then writes back each touched store byte of it.
// Requests: one at a time; a new one is accepted only after the result of the
//   last one is loaded.
// Reset: after rst_ni rises, a clearing pass zeroes the store, one byte a cycle,
//   over all STORE_BYTES bytes (1024 by default); no request is accepted until it ends.
module mono_framebuffer_rect_draw #(
  parameter int unsigned DISP_WIDTH  = 128,
  parameter int unsigned DISP_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] pos_x, [15:8] pos_y, [23:16] rect_width, [31:24] rect_height,
  // [32] fill_mode, [33] pixel_value, [43:34] byte_addr, [47:44] zero
  input  logic [47:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser_i,
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data
  output logic [7:0]  m_axis_tdata_o
);

  mfrd_pkg::cmd_t cmd;
  mfrd_pkg::sts_t sts;

  // Sequence the work: one request from accept to result, then idle again
  mfrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Unpack the request fields straight from the bus; the datapath latches
  // them on accept, so nothing here needs to hold them.
  mfrd_dp #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (s_axis_tuser_i),
    .pos_x_i       (s_axis_tdata_i[7:0]),
    .pos_y_i       (s_axis_tdata_i[15:8]),
    .rect_width_i  (s_axis_tdata_i[23:16]),
    .rect_height_i (s_axis_tdata_i[31:24]),
    .fill_mode_i   (s_axis_tdata_i[32]),
    .pixel_value_i (s_axis_tdata_i[33]),
    .byte_addr_i   (s_axis_tdata_i[43:34]),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_data_o    (m_axis_tdata_o)
  );

  // A store write never overlaps a cycle in which a new request may land
  a_no_write_when_ready : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.clr_step || cmd.wr_draw) |-> !s_axis_tready_o
  ) else $error("store written while accepting requests");

  // Once a request is taken, the block is busy in the next cycle
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o
  ) else $error("request accepted twice in a row");

  // A result never overwrites one that is still stalled at the output
  a_no_result_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid_o && !m_axis_tready_i)
  ) else $error("result register overwritten while stalled");

  // Accepting a request never coincides with a result load or a store read
  a_single_cmd_source : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !(cmd.out_load || cmd.rd_draw || cmd.rd_byte)
  ) else $error("accept overlaps other datapath work");

endmodule
